@@ rtl/tbhr_pkg.sv @@
`default_nettype none

package tbhr_pkg;

   // state codes, also the result code
   localparam logic [3:0] ST_NONE   = 4'd0;
   localparam logic [3:0] ST_1_HELD = 4'd1;
   localparam logic [3:0] ST_1_ACT  = 4'd2;
   localparam logic [3:0] ST_1_REP  = 4'd3;
   localparam logic [3:0] ST_2_HELD = 4'd4;
   localparam logic [3:0] ST_2_ACT  = 4'd5;
   localparam logic [3:0] ST_2_REP  = 4'd6;
   localparam logic [3:0] ST_B_HELD = 4'd7;
   localparam logic [3:0] ST_B_ACT  = 4'd8;
   localparam logic [3:0] ST_B_REP  = 4'd9;

   localparam logic [7:0] THRESHOLD_RESET = 8'd10;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic first_pressed;
      logic second_pressed;
   } req_type;

   typedef struct packed {
      logic [3:0] button_code;
      logic       changed;
   } rsp_type;

   // outcome of one tick, from the step logic to the top level
   typedef struct packed {
      logic [3:0] next_state;
      logic [7:0] next_count;
      logic       changed;
   } step_type;

endpackage

`default_nettype wire

@@ rtl/two_button_hold_repeat_fsm.sv @@
// two-button hold/repeat state machine with a debounce counter
//
// req channel: one beat per polling tick, carrying the two pressed flags
//   (req_valid / req_stall / req_data). a beat is taken when req_valid is
//   high and req_stall is low.
// rsp channel: one beat per tick with the new state code and a changed flag
//   (rsp_valid / rsp_stall / rsp_data), taken when rsp_stall is low.
// csr channel: write of the debounce threshold (csr_valid / csr_ready /
//   csr_data); always ready, write it while the block is idle.
// path: a taken tick is held in the input register, then passes through
//   the step logic into the result register.
// throughput: one tick per cycle unless the result stalls; the next state
//   comes from a single pass of logic between the input and result registers.
// reset: state goes to none, tick counter to 0, threshold to 10, both
//   pipeline registers empty.
// stall: a stalled result holds; the input register then fills and, if
//   also full, req_stall rises in the same cycle as rsp_stall.
`default_nettype none

module two_button_hold_repeat_fsm
   import tbhr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [7:0] csr_data
);

   // input register
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // machine state and threshold
   logic [3:0] fsm_state_ff;
   logic [7:0] tick_count_ff;
   logic [7:0] threshold_ff;

   logic     out_free;
   logic     advance;
   step_type step;

   // result slot is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   tbhr_step u_step (
      .state     (fsm_state_ff),
      .count     (tick_count_ff),
      .threshold (threshold_ff),
      .buttons   (in_data_ff),
      .step      (step)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fsm_state_ff  <= ST_NONE;
         tick_count_ff <= '0;
         threshold_ff  <= THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fsm_state_ff  <= step.next_state;
            tick_count_ff <= step.next_count;
         end
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.button_code <= step.next_state;
         rsp_data_ff.changed     <= step.changed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a state change restarts the counter
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      advance && step.changed |=> tick_count_ff == '0)
      else $error("tick counter not cleared on state change");

   // the shown result always carries the current state
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.button_code == fsm_state_ff)
      else $error("result code differs from machine state");

   // state never leaves the defined code range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      fsm_state_ff <= ST_B_REP)
      else $error("machine state outside defined codes");

   // state only moves when a beat passes to the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(fsm_state_ff))
      else $error("machine state moved without a beat");

endmodule

`default_nettype wire

@@ rtl/tbhr_step.sv @@
`default_nettype none

module tbhr_step
   import tbhr_pkg::*;
(
   input  wire logic [3:0] state,
   input  wire logic [7:0] count,
   input  wire logic [7:0] threshold,
   input  wire req_type    buttons,
   output step_type        step
);

   logic       p1;
   logic       p2;
   logic       both;
   logic       ripe;
   logic [3:0] nxt;

   assign p1   = buttons.first_pressed;
   assign p2   = buttons.second_pressed;
   assign both = p1 & p2;
   assign ripe = count >= threshold;

   always_comb begin
      case (state)
         ST_NONE: begin
            if (both)    nxt = ST_B_HELD;
            else if (p1) nxt = ST_1_HELD;
            else if (p2) nxt = ST_2_HELD;
            else         nxt = ST_NONE;
         end
         ST_1_HELD: begin
            if (!p1)       nxt = ST_NONE;
            else if (p2)   nxt = ST_B_HELD;
            else if (ripe) nxt = ST_1_ACT;
            else           nxt = ST_1_HELD;
         end
         ST_2_HELD: begin
            if (!p2)       nxt = ST_NONE;
            else if (p1)   nxt = ST_B_HELD;
            else if (ripe) nxt = ST_2_ACT;
            else           nxt = ST_2_HELD;
         end
         ST_B_HELD: begin
            if (!both)     nxt = ST_NONE;
            else if (ripe) nxt = ST_B_ACT;
            else           nxt = ST_B_HELD;
         end
         ST_1_ACT, ST_1_REP: nxt = p1   ? ST_1_REP : ST_NONE;
         ST_2_ACT, ST_2_REP: nxt = p2   ? ST_2_REP : ST_NONE;
         ST_B_ACT, ST_B_REP: nxt = both ? ST_B_REP : ST_NONE;
         default:            nxt = ST_NONE;
      endcase
   end

   always_comb begin
      step.next_state = nxt;
      step.changed    = nxt != state;
      if (step.changed)          step.next_count = '0;
      else if (count == COUNT_MAX) step.next_count = COUNT_MAX;
      else                       step.next_count = count + 8'd1;
   end

endmodule

`default_nettype wire
